>>> hdl/lir_pkg.sv
// shared types and constants for the linear interpolation resampler
// no dependencies; imported by every module of the block
package lir_pkg;

    localparam int RATE_W       = 18;
    localparam int WHOLE_W      = 32;
    localparam int BUDGET_W     = 40;
    localparam int SHORT_W      = 20;
    localparam int MAX_RESULTS  = 64;
    localparam int N_W          = $clog2(MAX_RESULTS + 1);
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int DEF_MAX_UPSAMPLE = 16;

    localparam logic [RATE_W-1:0] IN_RATE_RST  = RATE_W'(48000);
    localparam logic [RATE_W-1:0] OUT_RATE_RST = RATE_W'(16000);

    // register index, taken from paddr[2]
    localparam logic REG_IN_RATE  = 1'b0;
    localparam logic REG_OUT_RATE = 1'b1;

    typedef struct packed {
        logic [RATE_W-1:0] in_rate;
        logic [RATE_W-1:0] out_rate;
    } rates_t;

    typedef struct packed {
        logic start;
        logic short_op;
    } div_req_t;

    typedef struct packed {
        logic done;
    } div_rsp_t;

endpackage

>>> hdl/lir_cfg.sv
// apb register file holding the two rate registers
// depends on lir_pkg
module lir_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lir_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lir_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lir_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output lir_pkg::rates_t                 rates
);
    import lir_pkg::*;

    logic [RATE_W-1:0] in_rate_reg;
    logic [RATE_W-1:0] out_rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_rate_reg  <= IN_RATE_RST;
            out_rate_reg <= OUT_RATE_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_IN_RATE:  in_rate_reg  <= pwdata[RATE_W-1:0];
                REG_OUT_RATE: out_rate_reg <= pwdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_IN_RATE:  prdata = APB_DATA_W'(in_rate_reg);
            REG_OUT_RATE: prdata = APB_DATA_W'(out_rate_reg);
            default:      prdata = '0;
        endcase
    end

    assign pready         = 1'b1;
    assign rates.in_rate  = in_rate_reg;
    assign rates.out_rate = out_rate_reg;

endmodule

>>> hdl/lir_div.sv
// shared restoring divider, two quotient bits per cycle
// depends on lir_pkg; serves the phase and the interpolation divides
module lir_div #(
    parameter int DIV_W = 34
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lir_pkg::div_req_t           req,
    input  logic [DIV_W-1:0]            dividend,
    input  logic [lir_pkg::RATE_W-1:0]  divisor,
    output lir_pkg::div_rsp_t           rsp,
    output logic [DIV_W-1:0]            quotient,
    output logic [lir_pkg::RATE_W-1:0]  remainder
);
    import lir_pkg::*;

    localparam int CNT_W = $clog2(DIV_W / 2 + 1);

    logic [DIV_W-1:0]  q_reg;
    logic [RATE_W-1:0] r_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [RATE_W:0]   t1, t2;
    logic              ge1, ge2;
    logic [RATE_W-1:0] r1, r2;
    logic [DIV_W-1:0]  q1, q2;

    always_comb
    begin
        t1  = {r_reg, q_reg[DIV_W-1]};
        ge1 = t1 >= {1'b0, divisor};
        r1  = ge1 ? RATE_W'(t1 - {1'b0, divisor}) : RATE_W'(t1);
        q1  = {q_reg[DIV_W-2:0], ge1};
        t2  = {r1, q1[DIV_W-1]};
        ge2 = t2 >= {1'b0, divisor};
        r2  = ge2 ? RATE_W'(t2 - {1'b0, divisor}) : RATE_W'(t2);
        q2  = {q1[DIV_W-2:0], ge2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.short_op ? CNT_W'(SHORT_W / 2) : CNT_W'(DIV_W / 2);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // narrow dividends are shifted to the top so fewer steps finish them
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg <= req.short_op ? (dividend << (DIV_W - SHORT_W)) : dividend;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg <= q2;
            r_reg <= r2;
        end
    end

    assign rsp.done  = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

>>> hdl/lir_seq.sv
// sequencer and datapath: phase tracking, output credit, interpolation
// depends on lir_pkg; drives the shared divider lir_div
module lir_seq #(
    parameter int SAMPLE_BITS  = lir_pkg::DEF_SAMPLE_BITS,
    parameter int MAX_UPSAMPLE = lir_pkg::DEF_MAX_UPSAMPLE,
    parameter int DIV_W        = 34
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lir_pkg::rates_t             rates,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [SAMPLE_BITS-1:0]      in_sample,
    input  logic                        in_last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [SAMPLE_BITS-1:0]      out_sample,
    output logic                        out_last,
    output lir_pkg::div_req_t           div_req,
    input  lir_pkg::div_rsp_t           div_rsp,
    output logic [DIV_W-1:0]            div_dividend,
    output logic [lir_pkg::RATE_W-1:0]  divisor,
    input  logic [DIV_W-1:0]            div_quotient,
    input  logic [lir_pkg::RATE_W-1:0]  div_remainder
);
    import lir_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int PW    = SB + 20;
    localparam int LIM_W = RATE_W + $clog2(MAX_UPSAMPLE + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_REN, S_REN_WAIT, S_LOOP, S_CHECK, S_PDIV, S_PDIV_WAIT,
        S_ADV, S_ADV_WAIT, S_FIN, S_FLUSH
    } state_t;

    state_t                 state_reg;
    logic [SB-1:0]          x_reg;
    logic                   last_reg;
    logic [SB-1:0]          prev_reg;
    logic [SB-1:0]          first_reg;
    logic [WHOLE_W-1:0]     k_reg;
    logic [WHOLE_W-1:0]     whole_reg;
    logic [RATE_W-1:0]      rem_reg;
    logic [BUDGET_W-1:0]    budget_reg;
    logic                   any_reg;
    logic                   held_valid_reg;
    logic [SB-1:0]          held_reg;
    logic [N_W-1:0]         n_reg;
    logic [RATE_W-1:0]      inr_reg;
    logic [RATE_W-1:0]      outr_reg;
    logic signed [PW-1:0]   prod_reg;
    logic                   neg_reg;
    logic                   pend_valid_reg;
    logic [SB-1:0]          pend_reg;
    logic                   out_valid_reg;
    logic [SB-1:0]          out_data_reg;
    logic                   out_last_reg;
    logic                   div_start_reg;
    logic                   div_short_reg;
    logic [DIV_W-1:0]       dvd_reg;

    logic [RATE_W-1:0]      inr_c;
    logic [RATE_W-1:0]      outnz_c;
    logic [LIM_W-1:0]       lim_c;
    logic [RATE_W-1:0]      outr_c;
    logic                   slot_free;
    logic [WHOLE_W-1:0]     d_c;
    logic                   behind_c;
    logic                   at_end_c;
    logic signed [SB:0]     diff_c;
    logic signed [PW-1:0]   prod_c;
    logic [PW-1:0]          prod_mag_c;
    logic signed [SB+1:0]   q_mag_c;
    logic signed [SB+1:0]   t_c;
    logic signed [SB+1:0]   v_c;
    logic [RATE_W:0]        s_c;
    logic [RATE_W:0]        s_sub_c;
    logic [BUDGET_W:0]      bsum_c;
    logic                   can_emit_c;
    logic                   need_first_c;

    always_comb
    begin
        inr_c   = (rates.in_rate == '0) ? RATE_W'(1) : rates.in_rate;
        outnz_c = (rates.out_rate == '0) ? RATE_W'(1) : rates.out_rate;
        lim_c   = LIM_W'(MAX_UPSAMPLE) * LIM_W'(inr_c);
        outr_c  = (LIM_W'(outnz_c) > lim_c) ? RATE_W'(lim_c) : outnz_c;

        slot_free = !out_valid_reg || out_ready;

        // modular distance from the next output position to the newest sample
        d_c      = k_reg - whole_reg;
        behind_c = (d_c != '0) && !d_c[WHOLE_W-1];
        at_end_c = last_reg && (d_c == '0);

        diff_c     = $signed({x_reg[SB-1], x_reg}) - $signed({prev_reg[SB-1], prev_reg});
        prod_c     = diff_c * $signed({1'b0, rem_reg});
        prod_mag_c = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
        q_mag_c    = $signed((SB+2)'(div_quotient));
        t_c        = neg_reg ? -q_mag_c : q_mag_c;
        v_c        = $signed({{2{prev_reg[SB-1]}}, prev_reg}) + t_c;

        s_c     = {1'b0, rem_reg} + {1'b0, inr_reg};
        s_sub_c = s_c - {1'b0, outr_reg};
        bsum_c  = {1'b0, budget_reg} + (BUDGET_W+1)'(outr_reg);

        can_emit_c   = (budget_reg >= BUDGET_W'(inr_reg)) && (n_reg < N_W'(MAX_RESULTS));
        need_first_c = last_reg && !any_reg && (n_reg < N_W'(MAX_RESULTS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prev_reg       <= '0;
            first_reg      <= '0;
            k_reg          <= '0;
            whole_reg      <= '0;
            rem_reg        <= '0;
            budget_reg     <= '0;
            any_reg        <= 1'b0;
            held_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            div_short_reg  <= 1'b0;
            n_reg          <= '0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        x_reg    <= in_sample;
                        last_reg <= in_last;
                        inr_reg  <= inr_c;
                        outr_reg <= outr_c;
                        n_reg    <= '0;
                        if (k_reg == '0)
                            first_reg <= in_sample;
                        state_reg <= S_REN;
                    end
                end

                // bring the remainder back under the current out_rate, add credit
                S_REN:
                begin
                    budget_reg <= bsum_c[BUDGET_W] ? '1 : bsum_c[BUDGET_W-1:0];
                    if (rem_reg >= outr_reg)
                    begin
                        dvd_reg       <= DIV_W'(rem_reg);
                        div_short_reg <= 1'b1;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_REN_WAIT;
                    end
                    else
                        state_reg <= S_LOOP;
                end

                S_REN_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        whole_reg <= whole_reg + WHOLE_W'(div_quotient);
                        rem_reg   <= div_remainder;
                        state_reg <= S_LOOP;
                    end
                end

                S_LOOP:
                begin
                    if (!held_valid_reg)
                        state_reg <= S_CHECK;
                    else if (!can_emit_c)
                        state_reg <= S_FIN;
                    else if (!(pend_valid_reg && !slot_free))
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            out_data_reg  <= pend_reg;
                            out_last_reg  <= 1'b0;
                        end
                        pend_reg       <= held_reg;
                        pend_valid_reg <= 1'b1;
                        budget_reg     <= budget_reg - BUDGET_W'(inr_reg);
                        held_valid_reg <= 1'b0;
                        any_reg        <= 1'b1;
                        n_reg          <= n_reg + N_W'(1);
                        state_reg      <= S_CHECK;
                    end
                end

                S_CHECK:
                begin
                    if (at_end_c)
                    begin
                        held_reg  <= x_reg;
                        state_reg <= S_ADV;
                    end
                    else if (behind_c)
                    begin
                        prod_reg  <= prod_c;
                        state_reg <= S_PDIV;
                    end
                    else
                        state_reg <= S_FIN;
                end

                S_PDIV:
                begin
                    neg_reg       <= prod_reg[PW-1];
                    dvd_reg       <= DIV_W'(prod_mag_c);
                    div_short_reg <= 1'b0;
                    div_start_reg <= 1'b1;
                    state_reg     <= S_PDIV_WAIT;
                end

                S_PDIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        held_reg  <= v_c[SB-1:0];
                        state_reg <= S_ADV;
                    end
                end

                // step the phase by in_rate / out_rate
                S_ADV:
                begin
                    if (s_c < {1'b0, outr_reg})
                    begin
                        rem_reg        <= RATE_W'(s_c);
                        held_valid_reg <= 1'b1;
                        state_reg      <= S_LOOP;
                    end
                    else if (s_sub_c < {1'b0, outr_reg})
                    begin
                        whole_reg      <= whole_reg + WHOLE_W'(1);
                        rem_reg        <= RATE_W'(s_sub_c);
                        held_valid_reg <= 1'b1;
                        state_reg      <= S_LOOP;
                    end
                    else
                    begin
                        dvd_reg       <= DIV_W'(s_c);
                        div_short_reg <= 1'b1;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_ADV_WAIT;
                    end
                end

                S_ADV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        whole_reg      <= whole_reg + WHOLE_W'(div_quotient);
                        rem_reg        <= div_remainder;
                        held_valid_reg <= 1'b1;
                        state_reg      <= S_LOOP;
                    end
                end

                S_FIN:
                begin
                    if (!(need_first_c && pend_valid_reg && !slot_free))
                    begin
                        // a run that released nothing yields its first sample
                        if (need_first_c)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_reg <= 1'b1;
                                out_data_reg  <= pend_reg;
                                out_last_reg  <= 1'b0;
                            end
                            pend_reg       <= first_reg;
                            pend_valid_reg <= 1'b1;
                        end
                        if (last_reg)
                        begin
                            k_reg          <= '0;
                            whole_reg      <= '0;
                            rem_reg        <= '0;
                            budget_reg     <= '0;
                            any_reg        <= 1'b0;
                            held_valid_reg <= 1'b0;
                        end
                        else
                            k_reg <= k_reg + WHOLE_W'(1);
                        prev_reg  <= x_reg;
                        state_reg <= S_FLUSH;
                    end
                end

                S_FLUSH:
                begin
                    if (!pend_valid_reg)
                        state_reg <= S_IDLE;
                    else if (slot_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_data_reg   <= pend_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready         = (state_reg == S_IDLE);
    assign out_valid        = out_valid_reg;
    assign out_sample       = out_data_reg;
    assign out_last         = out_last_reg;
    assign div_req.start    = div_start_reg;
    assign div_req.short_op = div_short_reg;
    assign div_dividend     = dvd_reg;
    assign divisor          = outr_reg;

endmodule

>>> hdl/linear_interp_resampler.sv
// top level of the linear interpolation sample-rate converter
// depends on lir_pkg, lir_cfg, lir_div and lir_seq
//
// Usage: mono signed samples enter on the s_axis channel, one per beat, with
// s_axis_tlast on the final sample of a buffer. Resampled samples leave on
// m_axis; m_axis_tlast marks the last output caused by one input beat. An
// input beat may cause no output, or up to sixty-four (at most sixteen in
// steady state). in_rate and out_rate are written over apb at 0x0 and 0x4;
// the user must do so only while the block is idle, which it does not enforce.
// Work: an input beat steps the sequencer through its states; per output it adds
// a full-width divide for an interpolated value, none for a copy of the final sample
// (DIV_W = 34 at 16-bit samples); a phase step spanning two or more source
// samples adds a short divide of SHORT_W bits, as does rescaling the phase after a
// rate change. The first output of a beat appears on m_axis once the next one is
// released, the last one as the beat's work ends.
// Reset returns the rates to 48000 and 16000 and clears all buffer state.
// A stalled m_axis holds the pending output; the block then waits until the
// result register frees up, and s_axis_tready stays low until it is idle again.
module linear_interp_resampler #(
    parameter int SAMPLE_BITS  = lir_pkg::DEF_SAMPLE_BITS,
    parameter int MAX_UPSAMPLE = lir_pkg::DEF_MAX_UPSAMPLE
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lir_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [lir_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lir_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // fields from bit 0: sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // fields from bit 0: out_sample
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast
);
    import lir_pkg::*;

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int DIV_W   = ((SAMPLE_BITS + 19) / 2) * 2;

    rates_t                 rates;
    div_req_t               div_req;
    div_rsp_t               div_rsp;
    logic [DIV_W-1:0]       div_dividend;
    logic [DIV_W-1:0]       div_quotient;
    logic [RATE_W-1:0]      divisor;
    logic [RATE_W-1:0]      div_remainder;
    logic [SAMPLE_BITS-1:0] out_sample;

    lir_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rates   (rates)
    );

    lir_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (div_dividend),
        .divisor   (divisor),
        .rsp       (div_rsp),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    lir_seq #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .MAX_UPSAMPLE (MAX_UPSAMPLE),
        .DIV_W        (DIV_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .rates         (rates),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_sample     (s_axis_tdata[SAMPLE_BITS-1:0]),
        .in_last       (s_axis_tlast),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_sample    (out_sample),
        .out_last      (m_axis_tlast),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .div_dividend  (div_dividend),
        .divisor       (divisor),
        .div_quotient  (div_quotient),
        .div_remainder (div_remainder)
    );

    assign m_axis_tdata = TDATA_W'(out_sample);

endmodule

>>> hdl/lir_checker.sv
// port-level checks for linear_interp_resampler, bound to the top level
// depends on lir_pkg and the top level's port list
module lir_checker #(
    parameter int SAMPLE_BITS = lir_pkg::DEF_SAMPLE_BITS
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [lir_pkg::APB_ADDR_W-1:0]      paddr,
    input logic [lir_pkg::APB_DATA_W-1:0]      pwdata,
    input logic [lir_pkg::APB_DATA_W-1:0]      prdata,
    input logic                                pready,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,
    input logic                                m_axis_tlast
);
    import lir_pkg::*;

    // a stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // an accepted input keeps the block busy for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after a beat");

    // results are only produced while an item is being worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("output beat raised by an idle block");

    // a rate written is read back at the same address
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(psel && penable && pwrite && pready) && $stable(paddr) |->
            prdata == APB_DATA_W'($past(pwdata[RATE_W-1:0])))
        else $error("rate register readback mismatch");

endmodule

bind linear_interp_resampler lir_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_lir_checker (.*);

>>> dv/tb.sv
// self-checking testbench for linear_interp_resampler: apb rate writes, sample
// beats in, resampled beats out, checked against an in-bench predictor
// depends on lir_pkg and the linear_interp_resampler rtl
module tb;
    import lir_pkg::*;

    localparam int DATA_W        = ((DEF_SAMPLE_BITS + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 500;
    localparam longint unsigned CREDIT_MAX = 64'h00FF_FFFF_FFFF;

    typedef struct packed {
        logic [DEF_SAMPLE_BITS-1:0] smp;
        logic                       eor;
    } resampled_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [DATA_W-1:0]       s_axis_tdata = '0;   // fields from bit 0: sample
    logic                    s_axis_tlast = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [DATA_W-1:0]       m_axis_tdata;        // fields from bit 0: out_sample
    logic                    m_axis_tlast;

    int src_gap_pct = 0;
    int sink_stall_pct = 0;
    int error_count = 0;

    int audio_rates [0:8] = '{8000, 11025, 16000, 22050, 32000, 44100, 48000, 96000, 192000};
    logic [RATE_W-1:0] rate_extremes [0:3] = '{18'd0, 18'd1, 18'd192000, 18'h3FFFF};

    // predictor state
    logic [RATE_W-1:0]          cfg_in_rate = IN_RATE_RST;
    logic [RATE_W-1:0]          cfg_out_rate = OUT_RATE_RST;
    logic [DEF_SAMPLE_BITS-1:0] prev_smp = '0;
    logic [DEF_SAMPLE_BITS-1:0] first_smp = '0;
    logic [DEF_SAMPLE_BITS-1:0] held_val = '0;
    logic [WHOLE_W-1:0]         samples_in_buf = '0;
    logic [WHOLE_W-1:0]         pos_whole = '0;
    longint unsigned            pos_rem = 0;
    logic [BUDGET_W-1:0]        credit = '0;
    bit                         emitted_any = 1'b0;
    bit                         held_ok = 1'b0;

    resampled_t due_outputs [$];

    linear_interp_resampler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // works out the outputs that one accepted sample beat releases
    function automatic void resample_step(input logic [DEF_SAMPLE_BITS-1:0] x, input logic lst);
        longint unsigned inr;
        longint unsigned outr;
        longint unsigned step;
        longint unsigned budget;
        longint signed a;
        longint signed b;
        longint signed t;
        logic [WHOLE_W-1:0] k;
        logic [WHOLE_W-1:0] d;
        logic [DEF_SAMPLE_BITS-1:0] v;
        logic [DEF_SAMPLE_BITS-1:0] vals [$];
        bit behind;
        bit at_end;
        resampled_t beat;

        inr = (cfg_in_rate == '0) ? 1 : cfg_in_rate;
        outr = (cfg_out_rate == '0) ? 1 : cfg_out_rate;
        if (outr > DEF_MAX_UPSAMPLE * inr)
            outr = DEF_MAX_UPSAMPLE * inr;
        k = samples_in_buf;
        if (k == '0)
            first_smp = x;

        // renormalize the phase in case out_rate changed mid-buffer
        pos_whole = pos_whole + WHOLE_W'(pos_rem / outr);
        pos_rem = pos_rem % outr;

        budget = credit + outr;
        credit = (budget > CREDIT_MAX) ? CREDIT_MAX[BUDGET_W-1:0] : budget[BUDGET_W-1:0];

        while (1'b1)
        begin
            if (held_ok)
            begin
                if (credit >= inr && vals.size() < MAX_RESULTS)
                begin
                    vals.push_back(held_val);
                    credit = credit - BUDGET_W'(inr);
                    held_ok = 1'b0;
                    emitted_any = 1'b1;
                end
                else
                    break;
            end
            d = k - pos_whole;
            behind = (d >= 1) && (d < 32'h8000_0000);
            at_end = lst && (d == '0);
            if (!behind && !at_end)
                break;
            if (at_end)
                v = x;
            else
            begin
                a = $signed(prev_smp);
                b = $signed(x);
                t = ((b - a) * longint'(pos_rem)) / longint'(outr);
                v = DEF_SAMPLE_BITS'(a + t);
            end
            step = pos_rem + inr;
            pos_whole = pos_whole + WHOLE_W'(step / outr);
            pos_rem = step % outr;
            held_val = v;
            held_ok = 1'b1;
        end

        if (lst)
        begin
            // a buffer too short for any output still gives its first sample
            if (!emitted_any && vals.size() < MAX_RESULTS)
                vals.push_back(first_smp);
            samples_in_buf = '0;
            pos_whole = '0;
            pos_rem = 0;
            credit = '0;
            emitted_any = 1'b0;
            held_ok = 1'b0;
            held_val = '0;
        end
        else
            samples_in_buf = k + 1;
        prev_smp = x;

        for (int i = 0; i < vals.size(); i++)
        begin
            beat.smp = vals[i];
            beat.eor = (i == vals.size() - 1);
            due_outputs.push_back(beat);
        end
    endfunction

    always @(posedge clk)
    begin : check_outputs
        resampled_t due;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_outputs.size() == 0)
                report_mismatch($sformatf("unexpected beat %h", m_axis_tdata));
            else
            begin
                due = due_outputs.pop_front();
                if (m_axis_tdata[DEF_SAMPLE_BITS-1:0] !== due.smp)
                    report_mismatch($sformatf("out_sample got %h want %h",
                        m_axis_tdata[DEF_SAMPLE_BITS-1:0], due.smp));
                if (m_axis_tlast !== due.eor)
                    report_mismatch($sformatf("end_of_run got %b want %b",
                        m_axis_tlast, due.eor));
            end
        end
    end

    task automatic send_sample(input logic [DEF_SAMPLE_BITS-1:0] smp, input logic lst);
        while ($urandom_range(99) < src_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_W'(smp);
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        resample_step(smp, lst);
    endtask

    // block must be idle before a register write
    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        while (due_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate_reg(input logic reg_sel, input logic [RATE_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // read it back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_sel == REG_IN_RATE)
            cfg_in_rate = value;
        else
            cfg_out_rate = value;
        if (readback !== APB_DATA_W'(value))
            report_mismatch($sformatf("rate reg %b read %h want %h", reg_sel, readback, value));
    endtask

    task automatic set_rates(input logic [RATE_W-1:0] in_r, input logic [RATE_W-1:0] out_r);
        drain_outputs();
        write_rate_reg(REG_IN_RATE, in_r);
        write_rate_reg(REG_OUT_RATE, out_r);
    endtask

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(5))
            0, 1:    return RATE_W'(audio_rates[$urandom_range(8)]);
            2:       return RATE_W'($urandom_range(64, 1));
            3:       return RATE_W'($urandom_range(192000, 1));
            4:       return rate_extremes[$urandom_range(3)];
            default: return RATE_W'($urandom_range(262143));
        endcase
    endfunction

    function automatic logic [DEF_SAMPLE_BITS-1:0] next_sample(input logic [DEF_SAMPLE_BITS-1:0] prev);
        int pick;
        int delta;
        pick = $urandom_range(9);
        if (pick < 4)
            return DEF_SAMPLE_BITS'($urandom_range(65535));
        else if (pick < 8)
        begin
            // smooth signal, wraps at full scale
            delta = $urandom_range(600) - 300;
            return DEF_SAMPLE_BITS'(int'($signed(prev)) + delta);
        end
        else
            return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    endfunction

    task automatic test_reset_rates();
        // 3:1 down from reset values, then a one-sample buffer
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd12345, 1'b1);
        send_sample(16'h8000, 1'b1);
    endtask

    task automatic test_equal_rates();
        set_rates(18'd44100, 18'd44100);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'hFFFF, 1'b1);
    endtask

    task automatic test_max_upsample();
        // out_rate well above sixteen times in_rate
        set_rates(18'd1, 18'h3FFFF);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);
    endtask

    task automatic test_zero_rates();
        set_rates(18'd0, 18'd0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        // extreme downsampling leaves only the first sample
        set_rates(18'h3FFFF, 18'd0);
        send_sample(16'd100, 1'b0);
        send_sample(16'd200, 1'b0);
        send_sample(16'd300, 1'b1);
    endtask

    task automatic test_rate_change_mid_buffer();
        set_rates(18'd3, 18'd7);
        send_sample(16'd1000, 1'b0);
        send_sample(-16'sd1000, 1'b0);
        send_sample(16'd30000, 1'b0);
        send_sample(-16'sd30000, 1'b0);
        set_rates(18'd7, 18'd3);
        send_sample(-16'sd5, 1'b0);
        send_sample(16'd9, 1'b0);
        send_sample(16'h7FFF, 1'b1);
    endtask

    task automatic test_random_buffers(input int n_items, input int gap_pct, input int stall_pct);
        int sent;
        int len;
        logic [DEF_SAMPLE_BITS-1:0] smp;
        src_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        sent = 0;
        smp = '0;
        while (sent < n_items)
        begin
            if ($urandom_range(2) == 0)
                set_rates(pick_rate(), pick_rate());
            len = ($urandom_range(3) == 0) ? $urandom_range(120, 40) : $urandom_range(24, 1);
            if (len > n_items - sent)
                len = n_items - sent;
            for (int i = 0; i < len; i++)
            begin
                if (i > 0 && $urandom_range(99) == 0)
                    set_rates(pick_rate(), pick_rate());
                smp = next_sample(smp);
                send_sample(smp, i == len - 1);
            end
            sent += len;
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_rates();
        test_equal_rates();
        test_max_upsample();
        test_zero_rates();
        test_rate_change_mid_buffer();
        test_random_buffers(100, 0, 0);
        test_random_buffers(100, 67, 0);
        test_random_buffers(100, 0, 67);
        test_random_buffers(100, 9, 9);

        drain_outputs();
        if (due_outputs.size() != 0)
            report_mismatch($sformatf("%0d outputs never arrived", due_outputs.size()));
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #80000000;
        $display("FAILURE");
        $finish;
    end

endmodule
